@@ rtl/ptt_pkg.sv @@
// Package for the programmable tick timer: shared types, register indexes
// and field widths. No dependencies.
`default_nettype none

package ptt_pkg;

    localparam int unsigned CntW  = 8;
    localparam int unsigned DivW  = 16;
    localparam int unsigned SelW  = 2;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned InDataW = 8;
    localparam int unsigned OutDataW = 24;

    // Register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_TIMER_ENABLE = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_CLOCK_SELECT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_RELOAD_VALUE = 2'd2;

    // Divider tap codes
    localparam logic [SelW-1:0] SEL_BIT9 = 2'd0;
    localparam logic [SelW-1:0] SEL_BIT3 = 2'd1;
    localparam logic [SelW-1:0] SEL_BIT5 = 2'd2;
    localparam logic [SelW-1:0] SEL_BIT7 = 2'd3;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [CntW-1:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic            timer_enable;
        logic [SelW-1:0] clock_select;
        logic [CntW-1:0] reload_value;
    } cfg_t;

    typedef struct packed {
        logic            req_type;
        logic [CntW-1:0] write_value;
    } item_t;

    typedef struct packed {
        logic            irq_request;
        logic [CntW-1:0] counter_value;
        logic [CntW-1:0] divider_high;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ptt_cfg_regs.sv @@
// Configuration registers of the programmable tick timer.
// Depends on ptt_pkg.
`default_nettype none

module ptt_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ptt_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [ptt_pkg::CfgDataW-1:0] cfg_wdata,
    output ptt_pkg::cfg_t                     cfg
);

    ptt_pkg::cfg_t cfg_reg;
    ptt_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            // keep only the low bits; index beyond the list is dropped
            unique case (cfg_index)
                ptt_pkg::REG_TIMER_ENABLE: cfg_next.timer_enable = cfg_wdata[0];
                ptt_pkg::REG_CLOCK_SELECT:
                    cfg_next.clock_select = cfg_wdata[ptt_pkg::SelW-1:0];
                ptt_pkg::REG_RELOAD_VALUE:
                    cfg_next.reload_value = cfg_wdata[ptt_pkg::CntW-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ptt_timer_core.sv @@
// Divider and timer counter state with the per-item update logic.
// Depends on ptt_pkg.
`default_nettype none

module ptt_timer_core (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step,
    input  wire ptt_pkg::item_t  item,
    input  wire ptt_pkg::cfg_t   cfg,
    output ptt_pkg::result_t result
);

    logic [ptt_pkg::DivW-1:0] div_reg;
    logic [ptt_pkg::DivW-1:0] div_next;
    logic [ptt_pkg::CntW-1:0] cnt_reg;
    logic [ptt_pkg::CntW-1:0] cnt_next;
    logic                     irq;
    logic                     rise;
    logic [ptt_pkg::DivW-1:0] div_inc;

    assign div_inc = div_reg + ptt_pkg::DivW'(1);

    // rising edge of the tapped divider bit across the increment
    always_comb begin
        unique case (cfg.clock_select)
            ptt_pkg::SEL_BIT9: rise = div_inc[9] & ~div_reg[9];
            ptt_pkg::SEL_BIT3: rise = div_inc[3] & ~div_reg[3];
            ptt_pkg::SEL_BIT5: rise = div_inc[5] & ~div_reg[5];
            ptt_pkg::SEL_BIT7: rise = div_inc[7] & ~div_reg[7];
            default:           rise = 1'b0;
        endcase
    end

    always_comb begin
        div_next = div_reg;
        cnt_next = cnt_reg;
        irq      = 1'b0;
        if (item.req_type == ptt_pkg::REQ_WRITE) begin
            cnt_next = item.write_value;
        end else begin
            div_next = div_inc;
            if (rise && cfg.timer_enable) begin
                if (cnt_reg == ptt_pkg::CNT_MAX) begin
                    cnt_next = cfg.reload_value;
                    irq      = 1'b1;
                end else begin
                    cnt_next = cnt_reg + ptt_pkg::CntW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= '0;
            cnt_reg <= '0;
        end else if (step) begin
            div_reg <= div_next;
            cnt_reg <= cnt_next;
        end
    end

    assign result.divider_high  = div_next[ptt_pkg::DivW-1 -: ptt_pkg::CntW];
    assign result.counter_value = cnt_next;
    assign result.irq_request   = irq;

endmodule

`default_nettype wire

@@ rtl/programmable_tick_timer.sv @@
// Top level of the programmable tick timer: stream ports, input register,
// result register. Depends on ptt_pkg, ptt_cfg_regs and ptt_timer_core.
`default_nettype none

// Programmable tick timer. Every tick item advances a 16-bit free-running
// divider; when the divider bit picked by clock_select (bit 9, 3, 5 or 7)
// rises and the timer is enabled, the 8-bit counter increments, and on the
// wrap past 255 it takes reload_value and flags irq_request for that item
// only. A write item (tuser high) loads the counter and leaves the divider
// alone. Exactly one result leaves per item, in order. The block takes one
// item per clock unless m_tready holds the result register: an item sits
// in the input register, is processed by one pass of the divider/counter
// update as it moves into the result register, and is offered on the
// master side from there. The counter state is updated in the same edge
// that fills the result register, which is what lets the next item follow
// directly. Configuration is to be written through cfg_wr_en/cfg_index/
// cfg_wdata only while no item is in flight; the block does not enforce it.
module programmable_tick_timer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [ptt_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [ptt_pkg::CfgDataW-1:0]  cfg_wdata,
    // input items
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [ptt_pkg::InDataW-1:0]   s_tdata,   // [7:0] write_value
    input  wire logic                          s_tuser,   // [0] req_type
    // result items
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [ptt_pkg::OutDataW-1:0]  m_tdata    // [7:0] divider_high,
                                                          // [15:8] counter_value,
                                                          // [16] irq_request,
                                                          // [23:17] zero
);

    ptt_pkg::cfg_t    cfg;
    ptt_pkg::item_t   in_reg;
    logic             in_valid_reg;
    ptt_pkg::result_t res_comb;
    ptt_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             advance;

    ptt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // result register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // move the held item into the result register and commit its state update
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    ptt_timer_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res_comb)
    );

    // input register: capture a new item whenever it empties or passes on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.req_type    <= s_tuser;
            in_reg.write_value <= s_tdata;
        end
    end

    // result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.irq_request, out_reg.counter_value,
                       out_reg.divider_high};

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for the programmable tick timer: a scripted opening
// followed by randomised items, each result checked against a typed-in
// value or a local model. Depends on ptt_pkg and programmable_tick_timer.
`timescale 1ns / 100ps

module testbench;
    import ptt_pkg::*;

    localparam int unsigned CLOCK_HALF      = 2;
    localparam int unsigned RESET_CYCLES    = 6;
    localparam int unsigned MAX_WAIT        = 19;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    localparam int unsigned BURST_TICKS     = 64;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned CYCLE_LIMIT     = 1_200_000;

    // Index past the end of the register list; writes to it must be ignored
    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_TICK, ROW_WRITE, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e            kind;
        logic [CfgIdxW-1:0]   index;
        logic [CntW-1:0]      value;
        logic                 typed;   // use the typed-in result, not the model's
        result_t              want;
    } step_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CfgIdxW-1:0]    cfg_index;
    logic [CfgDataW-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutDataW-1:0]   m_tdata;

    // Local copy of the timer state and its settings
    logic [DivW-1:0]       tick_divider = '0;
    logic [CntW-1:0]       timer_count  = '0;
    logic                  set_enable   = 1'b0;
    logic [SelW-1:0]       set_tap      = SEL_BIT9;
    logic [CntW-1:0]       set_reload   = '0;

    result_t               timer_results_due[$];
    step_row_t             script[$];

    // Knobs shared between the sending and receiving processes
    logic                  tx_gaps   = 1'b1;
    logic                  rx_stalls = 1'b1;
    int unsigned           rx_hold_cycles = 0;

    int unsigned           mismatch_count = 0;
    int unsigned           cycle_count    = 0;

    programmable_tick_timer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] write_value
        .s_tuser   (s_tuser),    // [0] req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)     // [7:0] divider_high, [15:8] counter_value,
                                 // [16] irq_request, [23:17] zero
    );

    always begin
        #CLOCK_HALF aclk = 1'b1;
        #CLOCK_HALF aclk = 1'b0;
    end

    // Hard stop: a hung handshake must not hang the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, timer_results_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // Advance the local timer by one item and return the result it should give.
    // A write loads the counter and leaves the divider alone; a tick advances the
    // divider and, if enabled, bumps the counter on a rise of the selected tap bit.
    function automatic result_t next_timer_result(input logic req,
                                                  input logic [CntW-1:0] value);
        logic [DivW-1:0] div_next;
        int unsigned     tap;
        logic            rise;
        result_t         r;

        r.irq_request = 1'b0;
        if (req == REQ_WRITE) begin
            timer_count = value;
        end else begin
            case (set_tap)
                SEL_BIT9: tap = 9;
                SEL_BIT3: tap = 3;
                SEL_BIT5: tap = 5;
                SEL_BIT7: tap = 7;
            endcase
            div_next = tick_divider + 1'b1;   // wraps from all ones to zero
            rise = div_next[tap] && !tick_divider[tap];
            tick_divider = div_next;
            if (rise && set_enable) begin
                if (timer_count == CNT_MAX) begin
                    timer_count   = set_reload;
                    r.irq_request = 1'b1;
                end else begin
                    timer_count = timer_count + 1'b1;
                end
            end
        end
        r.divider_high  = tick_divider[DivW-1 -: CntW];
        r.counter_value = timer_count;
        return r;
    endfunction

    function automatic void add_row(input row_kind_e kind, input logic [CfgIdxW-1:0] index,
                                    input logic [CntW-1:0] value, input logic typed,
                                    input result_t want);
        step_row_t row;
        row.kind  = kind;
        row.index = index;
        row.value = value;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    // Offer one item after a random gap, hold it until accepted, then book
    // its expected result. Called and returning on a rising edge.
    task automatic send_item(input logic req, input logic [CntW-1:0] value,
                             input logic typed, input result_t want);
        int unsigned gap;
        result_t     predicted;

        gap = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predicted = next_timer_result(req, value);
        timer_results_due.push_back(typed ? want : predicted);
    endtask

    // Stop offering items and wait until every booked result has come out,
    // then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One-cycle register write; the local settings follow the same masking
    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        case (index)
            REG_TIMER_ENABLE: set_enable = data[0];
            REG_CLOCK_SELECT: set_tap    = data[SelW-1:0];
            REG_RELOAD_VALUE: set_reload = data[CntW-1:0];
            default: ;   // unused index: drop the write
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Result sink: random back-pressure per item, plus a long hold-off on request
    initial begin : result_sink
        int unsigned stall;

        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            stall = rx_stalls ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare every accepted result with the oldest one due
    always @(posedge aclk) begin : result_check
        result_t due;
        result_t got;

        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (timer_results_due.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("cycle %0d: result %06h arrived with nothing due",
                             cycle_count, m_tdata);
                mismatch_count <= mismatch_count + 1;
            end else begin
                due = timer_results_due.pop_front();
                if (got.divider_high !== due.divider_high ||
                    got.counter_value !== due.counter_value ||
                    got.irq_request !== due.irq_request ||
                    m_tdata[OutDataW-1:$bits(result_t)] !== '0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"cycle %0d: expected div %02h cnt %02h irq %0b, ",
                                  "got div %02h cnt %02h irq %0b pad %0h"},
                                 cycle_count, due.divider_high, due.counter_value,
                                 due.irq_request, got.divider_high, got.counter_value,
                                 got.irq_request, m_tdata[OutDataW-1:$bits(result_t)]);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial begin : stimulus
        logic            req;
        logic [CntW-1:0] value;
        logic [CntW-1:0] raw;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_TIMER_ENABLE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_TICK;

        // Opening script. Straight after reset the timer is off and every
        // register is zero, so the first few results can be typed in.
        add_row(ROW_TICK,  REG_TIMER_ENABLE, 8'h5A, 1'b1, {1'b0, 8'h00, 8'h00});
        add_row(ROW_WRITE, REG_TIMER_ENABLE, 8'hFF, 1'b1, {1'b0, 8'hFF, 8'h00});
        add_row(ROW_WRITE, REG_TIMER_ENABLE, 8'h00, 1'b1, {1'b0, 8'h00, 8'h00});
        add_row(ROW_WRITE, REG_TIMER_ENABLE, 8'h80, 1'b1, {1'b0, 8'h80, 8'h00});
        // Disabled timer: divider moves, counter holds
        add_row(ROW_TICK,  REG_TIMER_ENABLE, 8'hA5, 1'b1, {1'b0, 8'h80, 8'h00});
        // Wide writes keep only the low bits; bit 3 tap, reload at the top
        add_row(ROW_REG,   REG_TIMER_ENABLE, 8'hFF, 1'b0, '0);
        add_row(ROW_REG,   REG_CLOCK_SELECT, 8'hFD, 1'b0, '0);
        add_row(ROW_REG,   REG_RELOAD_VALUE, 8'hFF, 1'b0, '0);
        add_row(ROW_REG,   REG_UNUSED,       8'h5A, 1'b0, '0);
        // Counter at its limit: the next tap edge wraps it and raises the request
        add_row(ROW_WRITE, REG_TIMER_ENABLE, 8'hFF, 1'b0, '0);
        for (int i = 0; i < 6; i++)
            add_row(ROW_TICK, REG_TIMER_ENABLE, 8'hC3, 1'b0, '0);
        add_row(ROW_REG,   REG_RELOAD_VALUE, 8'h00, 1'b0, '0);
        add_row(ROW_WRITE, REG_TIMER_ENABLE, 8'hFF, 1'b0, '0);
        for (int i = 0; i < 8; i++)
            add_row(ROW_TICK, REG_TIMER_ENABLE, 8'h3C, 1'b0, '0);
        // Switch off again with a wide value whose low bit is clear
        add_row(ROW_REG,   REG_TIMER_ENABLE, 8'hFE, 1'b0, '0);
        for (int i = 0; i < 2; i++)
            add_row(ROW_TICK, REG_TIMER_ENABLE, 8'hFF, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                drain_results();
                write_reg(script[i].index, script[i].value);
            end else begin
                send_item(script[i].kind == ROW_WRITE ? REQ_WRITE : REQ_TICK,
                          script[i].value, script[i].typed, script[i].want);
            end
        end

        // Random phases. Each picks new settings while the block is idle: every
        // tap in turn, reload at both ends and in between, the timer off in two.
        // Upper register bits are random to show they are dropped.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            raw = CntW'($urandom);
            raw[0] = (p == 2 || p == 6) ? 1'b0 : 1'b1;
            write_reg(REG_TIMER_ENABLE, raw);
            raw = CntW'($urandom);
            raw[SelW-1:0] = p[SelW-1:0];
            write_reg(REG_CLOCK_SELECT, raw);
            raw = CntW'($urandom);
            if (p == 0)
                raw = '0;
            else if (p == 1)
                raw = CNT_MAX;
            write_reg(REG_RELOAD_VALUE, raw);
            if (p == 5) begin
                raw = CntW'($urandom);
                write_reg(REG_UNUSED, raw);
            end

            // Phase 3: sink holds off while items keep coming, so the block backs
            // up and drops s_tready. Phase 7: no idling on either side.
            tx_gaps   = (p != 3 && p != 7);
            rx_stalls = (p != 7);
            if (p == 3)
                rx_hold_cycles = HOLD_OFF_CYCLES;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Phase 4: pause mid-way until the block has emptied
                if (p == 4 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                // Mostly ticks; writes lean towards the top so wraps come often
                req = ($urandom_range(0, 99) < 15) ? REQ_WRITE : REQ_TICK;
                if ($urandom_range(0, 1))
                    value = CntW'($urandom_range(8'hF8, 8'hFF));
                else
                    value = CntW'($urandom_range(0, 255));
                send_item(req, value, 1'b0, '0);
            end
        end

        // Closing burst at one item per cycle on the slowest tap, starting
        // with the counter close to its limit.
        drain_results();
        write_reg(REG_TIMER_ENABLE, 8'h01);
        write_reg(REG_CLOCK_SELECT, {6'b0, SEL_BIT9});
        write_reg(REG_RELOAD_VALUE, 8'h80);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_item(REQ_WRITE, 8'hFC, 1'b0, '0);
        for (int k = 0; k < BURST_TICKS; k++) begin
            value = CntW'($urandom_range(0, 255));
            send_item(REQ_TICK, value, 1'b0, '0);
        end

        drain_results();
        if (mismatch_count == 0 && timer_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/ptt_pkg.sv
rtl/ptt_cfg_regs.sv
rtl/ptt_timer_core.sv
rtl/programmable_tick_timer.sv
tb/testbench.sv
